>>> rtl/qolm_pkg.sv
// Package for the quadrotor observer / LQR / mixer block: gain table,
// register-file map, micro-op format and the fixed micro-program.
// Used by quadrotor_observer_lqr_mixer_unit; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package qolm_pkg;

  // micro-op kinds
  localparam logic [1:0] OP_MUL = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_SUB = 2'd2;

  // operand map: read-only sources first, then the writable file
  localparam logic [5:0] R_ZERO = 6'd0;
  localparam logic [5:0] R_ONE  = 6'd1;
  localparam logic [5:0] R_TX   = 6'd2;
  localparam logic [5:0] R_TY   = 6'd3;
  localparam logic [5:0] R_TZ   = 6'd4;
  localparam logic [5:0] R_GX   = 6'd5;
  localparam logic [5:0] R_GY   = 6'd6;
  localparam logic [5:0] R_GZ   = 6'd7;
  localparam logic [5:0] R_AZ   = 6'd8;
  localparam logic [5:0] R_FX   = 6'd9;
  localparam logic [5:0] R_FY   = 6'd10;
  localparam logic [5:0] R_RNG  = 6'd11;
  localparam logic [5:0] R_EQ   = 6'd12;
  localparam logic [5:0] R_HTH  = 6'd13;
  localparam logic [5:0] R_BASE = 6'd14;
  localparam logic [5:0] R_PX   = 6'd14;
  localparam logic [5:0] R_PY   = 6'd15;
  localparam logic [5:0] R_H    = 6'd16;
  localparam logic [5:0] R_YAW  = 6'd17;
  localparam logic [5:0] R_PIT  = 6'd18;
  localparam logic [5:0] R_ROL  = 6'd19;
  localparam logic [5:0] R_VX   = 6'd20;
  localparam logic [5:0] R_VY   = 6'd21;
  localparam logic [5:0] R_VZ   = 6'd22;
  localparam logic [5:0] R_PRX  = 6'd23;
  localparam logic [5:0] R_PRY  = 6'd24;
  localparam logic [5:0] R_GRAV = 6'd25;
  localparam logic [5:0] R_WX   = 6'd26;
  localparam logic [5:0] R_WY   = 6'd27;
  localparam logic [5:0] R_WZ   = 6'd28;
  localparam logic [5:0] R_ACC  = 6'd29;
  localparam logic [5:0] R_TQX  = 6'd30;
  localparam logic [5:0] R_TQY  = 6'd31;
  localparam logic [5:0] R_S    = 6'd32;
  localparam logic [5:0] R_P    = 6'd33;
  localparam logic [5:0] R_HT   = 6'd34;
  localparam logic [5:0] R_EH   = 6'd35;
  localparam logic [5:0] R_CX   = 6'd36;
  localparam logic [5:0] R_CY   = 6'd37;
  localparam logic [5:0] R_CZ   = 6'd38;
  localparam logic [5:0] R_THR  = 6'd39;
  // mixer temporaries reuse scratch that is dead by then
  localparam logic [5:0] R_XA   = R_S;
  localparam logic [5:0] R_XB   = R_P;
  localparam logic [5:0] R_YA   = R_HT;
  localparam logic [5:0] R_YB   = R_EH;
  localparam logic [5:0] R_ZA   = R_ACC;
  localparam logic [5:0] R_ZB   = R_GRAV;
  localparam logic [5:0] R_D    = R_TQX;
  localparam logic [5:0] R_M1   = R_TQY;
  localparam logic [5:0] R_M2   = R_CX;
  localparam logic [5:0] R_M3   = R_CY;
  localparam logic [5:0] R_M4   = R_CZ;

  localparam int RF_DEPTH = 26;
  localparam int EST_COUNT = 9; // estimates sit at the bottom of the file

  // gain magnitudes, 32 fraction bits, rounded to nearest
  localparam logic [63:0] E8  = 64'd100000000;
  localparam logic [63:0] E13 = 64'd10000000000000;
  localparam logic [63:0] E14 = 64'd100000000000000;

  localparam logic [63:0] G_DT = (((64'd2 << 16) / 64'd1000) << 16)
    + ((((64'd2 << 16) % 64'd1000) << 16) + 64'd1000 / 2) / 64'd1000;
  localparam logic [63:0] G_GRAV = (((64'd981 << 16) / 64'd100) << 16)
    + ((((64'd981 << 16) % 64'd100) << 16) + 64'd100 / 2) / 64'd100;
  localparam logic [63:0] G_DEG = (((64'd1745329251994 << 16) / E14) << 16)
    + ((((64'd1745329251994 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_JXDT = (((64'd7 << 16) / 64'd1000) << 16)
    + ((((64'd7 << 16) % 64'd1000) << 16) + 64'd1000 / 2) / 64'd1000;
  localparam logic [63:0] G_JYDT = (((64'd755 << 16) / 64'd100000) << 16)
    + ((((64'd755 << 16) % 64'd100000) << 16) + 64'd100000 / 2) / 64'd100000;
  localparam logic [63:0] G_OBS_H = (((64'd24348085654692 << 16) / E13) << 16)
    + ((((64'd24348085654692 << 16) % E13) << 16) + E13 / 2) / E13;
  localparam logic [63:0] G_OBS_TN = (((64'd310326377742 << 16) / E14) << 16)
    + ((((64'd310326377742 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_TV = (((64'd2540055959458 << 16) / E14) << 16)
    + ((((64'd2540055959458 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_PN = (((64'd186080731891 << 16) / E14) << 16)
    + ((((64'd186080731891 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_PV = (((64'd1523091512296 << 16) / E14) << 16)
    + ((((64'd1523091512296 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_XN = (((64'd8742261792886 << 16) / E14) << 16)
    + ((((64'd8742261792886 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_XV = (((64'd71556386304403 << 16) / E14) << 16)
    + ((((64'd71556386304403 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_YN = (((64'd6749059984201 << 16) / E14) << 16)
    + ((((64'd6749059984201 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_YV = (((64'd55241807539332 << 16) / E14) << 16)
    + ((((64'd55241807539332 << 16) % E14) << 16) + E14 / 2) / E14;
  localparam logic [63:0] G_OBS_VZ = (((64'd28565908196855 << 16) / E13) << 16)
    + ((((64'd28565908196855 << 16) % E13) << 16) + E13 / 2) / E13;
  localparam logic [63:0] G_RX_P = (((64'd1153626 << 16) / E8) << 16)
    + ((((64'd1153626 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_RX_A = (((64'd2190339 << 16) / E8) << 16)
    + ((((64'd2190339 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_RX_V = (((64'd762691 << 16) / E8) << 16)
    + ((((64'd762691 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_RX_W = (((64'd314458 << 16) / E8) << 16)
    + ((((64'd314458 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_RX_T = (((64'd449542642 << 16) / E8) << 16)
    + ((((64'd449542642 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_PY_P = (((64'd815737 << 16) / E8) << 16)
    + ((((64'd815737 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_PY_A = (((64'd2001104 << 16) / E8) << 16)
    + ((((64'd2001104 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_PY_V = (((64'd631934 << 16) / E8) << 16)
    + ((((64'd631934 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_PY_W = (((64'd311792 << 16) / E8) << 16)
    + ((((64'd311792 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_PY_T = (((64'd427664907 << 16) / E8) << 16)
    + ((((64'd427664907 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_YW_A = (((64'd125252 << 16) / E8) << 16)
    + ((((64'd125252 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_YW_W = (((64'd26410 << 16) / E8) << 16)
    + ((((64'd26410 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_FZ_P = (((64'd35649465 << 16) / E8) << 16)
    + ((((64'd35649465 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_FZ_V = (((64'd38846142 << 16) / E8) << 16)
    + ((((64'd38846142 << 16) % E8) << 16) + E8 / 2) / E8;
  localparam logic [63:0] G_MIX_T = (((64'd36982249 << 16) / 64'd10) << 16)
    + ((((64'd36982249 << 16) % 64'd10) << 16) + 64'd10 / 2) / 64'd10;
  localparam logic [63:0] G_MIX_Z = (((64'd1865671642 << 16) / 64'd10) << 16)
    + ((((64'd1865671642 << 16) % 64'd10) << 16) + 64'd10 / 2) / 64'd10;
  localparam logic [63:0] G_MIX_F = 64'd147929 << 32;

  // gain indexes
  localparam logic [4:0] GI_DT     = 5'd0;
  localparam logic [4:0] GI_GRAV   = 5'd1;
  localparam logic [4:0] GI_DEG    = 5'd2;
  localparam logic [4:0] GI_JXDT   = 5'd3;
  localparam logic [4:0] GI_JYDT   = 5'd4;
  localparam logic [4:0] GI_OBS_H  = 5'd5;
  localparam logic [4:0] GI_OBS_TN = 5'd6;
  localparam logic [4:0] GI_OBS_TV = 5'd7;
  localparam logic [4:0] GI_OBS_PN = 5'd8;
  localparam logic [4:0] GI_OBS_PV = 5'd9;
  localparam logic [4:0] GI_OBS_XN = 5'd10;
  localparam logic [4:0] GI_OBS_XV = 5'd11;
  localparam logic [4:0] GI_OBS_YN = 5'd12;
  localparam logic [4:0] GI_OBS_YV = 5'd13;
  localparam logic [4:0] GI_OBS_VZ = 5'd14;
  localparam logic [4:0] GI_RX_P   = 5'd15;
  localparam logic [4:0] GI_RX_A   = 5'd16;
  localparam logic [4:0] GI_RX_V   = 5'd17;
  localparam logic [4:0] GI_RX_W   = 5'd18;
  localparam logic [4:0] GI_RX_T   = 5'd19;
  localparam logic [4:0] GI_PY_P   = 5'd20;
  localparam logic [4:0] GI_PY_A   = 5'd21;
  localparam logic [4:0] GI_PY_V   = 5'd22;
  localparam logic [4:0] GI_PY_W   = 5'd23;
  localparam logic [4:0] GI_PY_T   = 5'd24;
  localparam logic [4:0] GI_YW_A   = 5'd25;
  localparam logic [4:0] GI_YW_W   = 5'd26;
  localparam logic [4:0] GI_FZ_P   = 5'd27;
  localparam logic [4:0] GI_FZ_V   = 5'd28;
  localparam logic [4:0] GI_MIX_T  = 5'd29;
  localparam logic [4:0] GI_MIX_Z  = 5'd30;
  localparam logic [4:0] GI_MIX_F  = 5'd31;

  function automatic logic [63:0] gain_mag(input logic [4:0] gi);
    logic [63:0] g;
    case (gi)
      GI_DT:     g = G_DT;
      GI_GRAV:   g = G_GRAV;
      GI_DEG:    g = G_DEG;
      GI_JXDT:   g = G_JXDT;
      GI_JYDT:   g = G_JYDT;
      GI_OBS_H:  g = G_OBS_H;
      GI_OBS_TN: g = G_OBS_TN;
      GI_OBS_TV: g = G_OBS_TV;
      GI_OBS_PN: g = G_OBS_PN;
      GI_OBS_PV: g = G_OBS_PV;
      GI_OBS_XN: g = G_OBS_XN;
      GI_OBS_XV: g = G_OBS_XV;
      GI_OBS_YN: g = G_OBS_YN;
      GI_OBS_YV: g = G_OBS_YV;
      GI_OBS_VZ: g = G_OBS_VZ;
      GI_RX_P:   g = G_RX_P;
      GI_RX_A:   g = G_RX_A;
      GI_RX_V:   g = G_RX_V;
      GI_RX_W:   g = G_RX_W;
      GI_RX_T:   g = G_RX_T;
      GI_PY_P:   g = G_PY_P;
      GI_PY_A:   g = G_PY_A;
      GI_PY_V:   g = G_PY_V;
      GI_PY_W:   g = G_PY_W;
      GI_PY_T:   g = G_PY_T;
      GI_YW_A:   g = G_YW_A;
      GI_YW_W:   g = G_YW_W;
      GI_FZ_P:   g = G_FZ_P;
      GI_FZ_V:   g = G_FZ_V;
      GI_MIX_T:  g = G_MIX_T;
      GI_MIX_Z:  g = G_MIX_Z;
      default:   g = G_MIX_F;
    endcase
    return g;
  endfunction

  typedef struct packed {
    logic [1:0] op;
    logic [5:0] dst;
    logic [5:0] a;
    logic [5:0] b;
    logic [4:0] g;
    logic       gneg;
  } uop_t;

  localparam int PROG_LEN = 106;
  localparam logic [6:0] PC_LAST = 7'(PROG_LEN - 1);

  function automatic uop_t mul(input logic [5:0] d, input logic [5:0] a,
                               input logic [4:0] g, input logic n);
    uop_t u;
    u = '{OP_MUL, d, a, R_ZERO, g, n};
    return u;
  endfunction

  function automatic uop_t alu(input logic [1:0] op, input logic [5:0] d,
                               input logic [5:0] a, input logic [5:0] b);
    uop_t u;
    u = '{op, d, a, b, GI_DT, 1'b0};
    return u;
  endfunction

  function automatic uop_t ucode(input logic [6:0] pc);
    uop_t u;
    case (pc)
      // unit conversion and torque estimate
      7'd0:   u = mul(R_GRAV, R_ONE, GI_GRAV, 1'b0);
      7'd1:   u = mul(R_WX, R_GX, GI_DEG, 1'b0);
      7'd2:   u = mul(R_WY, R_GY, GI_DEG, 1'b0);
      7'd3:   u = mul(R_WZ, R_GZ, GI_DEG, 1'b0);
      7'd4:   u = mul(R_ACC, R_AZ, GI_GRAV, 1'b0);
      7'd5:   u = alu(OP_SUB, R_S, R_WX, R_PRX);
      7'd6:   u = mul(R_TQX, R_S, GI_JXDT, 1'b0);
      7'd7:   u = alu(OP_SUB, R_S, R_WY, R_PRY);
      7'd8:   u = mul(R_TQY, R_S, GI_JYDT, 1'b0);
      7'd9:   u = alu(OP_ADD, R_PRX, R_WX, R_ZERO);
      7'd10:  u = alu(OP_ADD, R_PRY, R_WY, R_ZERO);
      // height
      7'd11:  u = alu(OP_SUB, R_HT, R_RNG, R_EQ);
      7'd12:  u = alu(OP_SUB, R_EH, R_H, R_EQ);
      7'd13:  u = mul(R_S, R_EH, GI_OBS_H, 1'b1);
      7'd14:  u = mul(R_P, R_HT, GI_OBS_H, 1'b0);
      7'd15:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd16:  u = alu(OP_ADD, R_S, R_S, R_VZ);
      7'd17:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd18:  u = alu(OP_ADD, R_H, R_H, R_P);
      // pitch
      7'd19:  u = mul(R_S, R_FX, GI_OBS_TN, 1'b0);
      7'd20:  u = mul(R_P, R_VX, GI_OBS_TV, 1'b1);
      7'd21:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd22:  u = alu(OP_ADD, R_S, R_S, R_WY);
      7'd23:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd24:  u = alu(OP_ADD, R_PIT, R_PIT, R_P);
      // roll
      7'd25:  u = mul(R_S, R_FY, GI_OBS_PN, 1'b1);
      7'd26:  u = mul(R_P, R_VY, GI_OBS_PV, 1'b0);
      7'd27:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd28:  u = alu(OP_ADD, R_S, R_S, R_WX);
      7'd29:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd30:  u = alu(OP_ADD, R_ROL, R_ROL, R_P);
      // vx
      7'd31:  u = mul(R_S, R_FX, GI_OBS_XN, 1'b0);
      7'd32:  u = mul(R_P, R_PIT, GI_GRAV, 1'b0);
      7'd33:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd34:  u = mul(R_P, R_VX, GI_OBS_XV, 1'b1);
      7'd35:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd36:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd37:  u = alu(OP_ADD, R_VX, R_VX, R_P);
      // vy
      7'd38:  u = mul(R_S, R_FY, GI_OBS_YN, 1'b0);
      7'd39:  u = mul(R_P, R_ROL, GI_GRAV, 1'b1);
      7'd40:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd41:  u = mul(R_P, R_VY, GI_OBS_YV, 1'b1);
      7'd42:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd43:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd44:  u = alu(OP_ADD, R_VY, R_VY, R_P);
      // vz, against the new height
      7'd45:  u = alu(OP_SUB, R_S, R_ACC, R_GRAV);
      7'd46:  u = alu(OP_SUB, R_EH, R_H, R_EQ);
      7'd47:  u = mul(R_P, R_EH, GI_OBS_VZ, 1'b1);
      7'd48:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd49:  u = mul(R_P, R_HT, GI_OBS_VZ, 1'b0);
      7'd50:  u = alu(OP_ADD, R_S, R_S, R_P);
      7'd51:  u = mul(R_P, R_S, GI_DT, 1'b0);
      7'd52:  u = alu(OP_ADD, R_VZ, R_VZ, R_P);
      // positions and yaw
      7'd53:  u = mul(R_P, R_VX, GI_DT, 1'b0);
      7'd54:  u = alu(OP_ADD, R_PX, R_PX, R_P);
      7'd55:  u = mul(R_P, R_VY, GI_DT, 1'b0);
      7'd56:  u = alu(OP_ADD, R_PY, R_PY, R_P);
      7'd57:  u = mul(R_P, R_WZ, GI_DT, 1'b0);
      7'd58:  u = alu(OP_ADD, R_YAW, R_YAW, R_P);
      // roll command
      7'd59:  u = alu(OP_SUB, R_S, R_PY, R_TY);
      7'd60:  u = mul(R_CX, R_S, GI_RX_P, 1'b0);
      7'd61:  u = mul(R_P, R_ROL, GI_RX_A, 1'b1);
      7'd62:  u = alu(OP_ADD, R_CX, R_CX, R_P);
      7'd63:  u = mul(R_P, R_VY, GI_RX_V, 1'b0);
      7'd64:  u = alu(OP_ADD, R_CX, R_CX, R_P);
      7'd65:  u = mul(R_P, R_WX, GI_RX_W, 1'b1);
      7'd66:  u = alu(OP_ADD, R_CX, R_CX, R_P);
      7'd67:  u = mul(R_P, R_TQX, GI_RX_T, 1'b1);
      7'd68:  u = alu(OP_ADD, R_CX, R_CX, R_P);
      // pitch command
      7'd69:  u = alu(OP_SUB, R_S, R_PX, R_TX);
      7'd70:  u = mul(R_CY, R_S, GI_PY_P, 1'b1);
      7'd71:  u = mul(R_P, R_PIT, GI_PY_A, 1'b1);
      7'd72:  u = alu(OP_ADD, R_CY, R_CY, R_P);
      7'd73:  u = mul(R_P, R_VX, GI_PY_V, 1'b1);
      7'd74:  u = alu(OP_ADD, R_CY, R_CY, R_P);
      7'd75:  u = mul(R_P, R_WY, GI_PY_W, 1'b1);
      7'd76:  u = alu(OP_ADD, R_CY, R_CY, R_P);
      7'd77:  u = mul(R_P, R_TQY, GI_PY_T, 1'b1);
      7'd78:  u = alu(OP_ADD, R_CY, R_CY, R_P);
      // yaw command and thrust
      7'd79:  u = mul(R_CZ, R_YAW, GI_YW_A, 1'b1);
      7'd80:  u = mul(R_P, R_WZ, GI_YW_W, 1'b1);
      7'd81:  u = alu(OP_ADD, R_CZ, R_CZ, R_P);
      7'd82:  u = alu(OP_SUB, R_S, R_H, R_TZ);
      7'd83:  u = mul(R_THR, R_S, GI_FZ_P, 1'b1);
      7'd84:  u = mul(R_P, R_VZ, GI_FZ_V, 1'b1);
      7'd85:  u = alu(OP_ADD, R_THR, R_THR, R_P);
      7'd86:  u = alu(OP_ADD, R_THR, R_THR, R_HTH);
      // mixer products; negated gain is not the negated product at saturation
      7'd87:  u = mul(R_XA, R_CX, GI_MIX_T, 1'b1);
      7'd88:  u = mul(R_XB, R_CX, GI_MIX_T, 1'b0);
      7'd89:  u = mul(R_YA, R_CY, GI_MIX_T, 1'b1);
      7'd90:  u = mul(R_YB, R_CY, GI_MIX_T, 1'b0);
      7'd91:  u = mul(R_ZA, R_CZ, GI_MIX_Z, 1'b1);
      7'd92:  u = mul(R_ZB, R_CZ, GI_MIX_Z, 1'b0);
      7'd93:  u = mul(R_D, R_THR, GI_MIX_F, 1'b0);
      7'd94:  u = alu(OP_ADD, R_M1, R_XA, R_YA);
      7'd95:  u = alu(OP_ADD, R_M1, R_M1, R_ZA);
      7'd96:  u = alu(OP_ADD, R_M1, R_M1, R_D);
      7'd97:  u = alu(OP_ADD, R_M2, R_XA, R_YB);
      7'd98:  u = alu(OP_ADD, R_M2, R_M2, R_ZB);
      7'd99:  u = alu(OP_ADD, R_M2, R_M2, R_D);
      7'd100: u = alu(OP_ADD, R_M3, R_XB, R_YB);
      7'd101: u = alu(OP_ADD, R_M3, R_M3, R_ZA);
      7'd102: u = alu(OP_ADD, R_M3, R_M3, R_D);
      7'd103: u = alu(OP_ADD, R_M4, R_XB, R_YA);
      7'd104: u = alu(OP_ADD, R_M4, R_M4, R_ZB);
      7'd105: u = alu(OP_ADD, R_M4, R_M4, R_D);
      default: u = alu(OP_ADD, R_S, R_ZERO, R_ZERO);
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

>>> rtl/quadrotor_observer_lqr_mixer_unit.sv
// Quadrotor observer, LQR controller and motor mixer: top level.
// Depends on qolm_pkg (gain table, operand map and micro-program).
//
// One control tick per input item. A small sequencer steps a 106-entry
// micro-program through one shared unit: a saturating 64-bit add/subtract
// and a 64x64 fixed-point multiply built from one 32x32 multiplier that
// forms the four partial products in turn. The program holds 51 multiplies
// and 55 adds. The result is registered once the last micro-op is done and
// the output register is free, and the input is ready again on the next
// cycle. The input is not ready from acceptance until then; a finished
// result waits in the output register while the next item is taken, and a
// second finished result holds the sequencer until the first has gone.
// Motor commands read zero when motors_enabled is low, but the estimates
// still advance.
`timescale 1ns / 1ps
`default_nettype none

module quadrotor_observer_lqr_mixer_unit #(
  parameter int INTERNAL_FRAC_BITS = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // target_x, target_y, target_z, motors_enabled, reset_estimate, gyro_x,
  // gyro_y, gyro_z, accel_z, flow_dx, flow_dy, range_distance, zero fill
  input  wire logic [311:0] s_tdata,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // motor_1, motor_2, motor_3, motor_4
  output logic [63:0]       m_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [19:0]  cfg_data
);
  import qolm_pkg::*;

  localparam int SH = INTERNAL_FRAC_BITS - 16;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LDA  = 3'd1;
  localparam logic [2:0] ST_LDB  = 3'd2;
  localparam logic [2:0] ST_ALU  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_MFIN = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, 63'd0};

  logic [2:0]  state;
  logic [6:0]  pc;
  uop_t        u;

  logic [19:0] hover_height;
  logic [18:0] hover_thrust;

  // latched item
  logic [31:0] tx, ty, tz, gx, gy, gz, az, fx, fy;
  logic [19:0] rng;
  logic        enabled;

  logic [63:0] rf [RF_DEPTH];

  logic [5:0]  rd_addr;
  logic [63:0] rd_val;
  logic [4:0]  rd_idx, wr_idx;

  logic [63:0] opa, opb, amag, bmag;
  logic        mneg;
  logic [127:0] acc;
  logic [1:0]  k;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [127:0] pp_sh;
  logic [63:0] mag, mul_res, alu_res;
  logic [64:0] alu_sum;
  logic [63:0] alu_b;
  logic [15:0] mot [4];

  assign u = ucode(pc);
  assign s_tready = (state == ST_IDLE);

  function automatic logic [63:0] from_s32(input logic [31:0] v);
    return {{32{v[31]}}, v} << SH;
  endfunction

  function automatic logic [63:0] from_u20(input logic [19:0] v);
    return {44'd0, v} << SH;
  endfunction

  function automatic logic [15:0] to_motor(input logic [63:0] v);
    logic [63:0] q;
    q = v >> INTERNAL_FRAC_BITS;
    if (v[63] || v == 64'd0) return 16'd0;
    return (|q[63:16]) ? 16'hFFFF : q[15:0];
  endfunction

  // operand read: one address per cycle
  assign rd_addr = (state == ST_LDB) ? u.b : u.a;
  assign rd_idx  = 5'(rd_addr - R_BASE);
  assign wr_idx  = 5'(u.dst - R_BASE);

  always_comb begin
    case (rd_addr)
      R_ZERO:  rd_val = 64'd0;
      R_ONE:   rd_val = 64'd1 << INTERNAL_FRAC_BITS;
      R_TX:    rd_val = from_s32(tx);
      R_TY:    rd_val = from_s32(ty);
      R_TZ:    rd_val = from_s32(tz);
      R_GX:    rd_val = from_s32(gx);
      R_GY:    rd_val = from_s32(gy);
      R_GZ:    rd_val = from_s32(gz);
      R_AZ:    rd_val = from_s32(az);
      R_FX:    rd_val = from_s32(fx);
      R_FY:    rd_val = from_s32(fy);
      R_RNG:   rd_val = from_u20(rng);
      R_EQ:    rd_val = from_u20(hover_height);
      R_HTH:   rd_val = from_u20({1'b0, hover_thrust});
      default: rd_val = rf[rd_idx];
    endcase
  end

  // multiply: one 32x32 partial product per cycle into a 128-bit sum
  assign pa = k[1] ? amag[63:32] : amag[31:0];
  assign pb = k[0] ? bmag[63:32] : bmag[31:0];

  always_comb begin
    pp = 64'(pa) * 64'(pb);
    if (k == 2'd0) begin
      pp_sh = {64'd0, pp};
    end else if (k == 2'd3) begin
      pp_sh = {pp, 64'd0};
    end else begin
      pp_sh = {32'd0, pp, 32'd0};
    end
  end

  // rounding bias went in at start, so only the saturation is left here
  assign mag = (|acc[127:96]) ? {64{1'b1}} : acc[95:32];
  always_comb begin
    if (mneg) begin
      mul_res = mag[63] ? S64_MIN : 64'(-mag);
    end else begin
      mul_res = mag[63] ? S64_MAX : mag;
    end
  end

  // saturating add/subtract
  assign alu_b   = (u.op == OP_SUB) ? ~opb : opb;
  assign alu_sum = {opa[63], opa} + {alu_b[63], alu_b} + {64'd0, (u.op == OP_SUB)};
  assign alu_res = (alu_sum[64] != alu_sum[63]) ? (alu_sum[64] ? S64_MIN : S64_MAX)
                                                : alu_sum[63:0];

  always_comb begin
    mot[0] = to_motor(rf[5'(R_M1 - R_BASE)]);
    mot[1] = to_motor(rf[5'(R_M2 - R_BASE)]);
    mot[2] = to_motor(rf[5'(R_M3 - R_BASE)]);
    mot[3] = to_motor(rf[5'(R_M4 - R_BASE)]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hover_height <= 20'd32768;
      hover_thrust <= 19'd21473;
    end else if (cfg_we) begin
      if (cfg_index == 1'b0) begin
        hover_height <= cfg_data;
      end else begin
        hover_thrust <= cfg_data[18:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pc       <= 7'd0;
      m_tvalid <= 1'b0;
      for (int i = 0; i < RF_DEPTH; i++) begin
        rf[i] <= 64'd0;
      end
    end else begin
      // the result stage reloads the output itself
      if (m_tvalid && m_tready && (state != ST_FIN)) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            tx      <= s_tdata[31:0];
            ty      <= s_tdata[63:32];
            tz      <= s_tdata[95:64];
            enabled <= s_tdata[96];
            gx      <= s_tdata[129:98];
            gy      <= s_tdata[161:130];
            gz      <= s_tdata[193:162];
            az      <= s_tdata[225:194];
            fx      <= s_tdata[257:226];
            fy      <= s_tdata[289:258];
            rng     <= s_tdata[309:290];
            // nothing before the observer reads the estimates
            if (s_tdata[97]) begin
              for (int i = 0; i < EST_COUNT; i++) begin
                rf[i] <= 64'd0;
              end
            end
            pc    <= 7'd0;
            state <= ST_LDA;
          end
        end
        ST_LDA: begin
          opa  <= rd_val;
          amag <= rd_val[63] ? 64'(-rd_val) : rd_val;
          mneg <= rd_val[63] ^ u.gneg;
          bmag <= gain_mag(u.g);
          acc  <= 128'd1 << 31;
          k    <= 2'd0;
          state <= (u.op == OP_MUL) ? ST_MUL : ST_LDB;
        end
        ST_LDB: begin
          opb   <= rd_val;
          state <= ST_ALU;
        end
        ST_MUL: begin
          acc <= acc + pp_sh;
          k   <= k + 2'd1;
          if (k == 2'd3) begin
            state <= ST_MFIN;
          end
        end
        ST_ALU, ST_MFIN: begin
          rf[wr_idx] <= (state == ST_MFIN) ? mul_res : alu_res;
          if (pc == PC_LAST) begin
            state <= ST_FIN;
          end else begin
            pc    <= pc + 7'd1;
            state <= ST_LDA;
          end
        end
        ST_FIN: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= enabled ? {mot[3], mot[2], mot[1], mot[0]} : 64'd0;
            m_tvalid <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_quadrotor_observer_lqr_mixer_unit.sv
// Testbench for quadrotor_observer_lqr_mixer_unit: streams control ticks, predicts
// the four motor commands with its own fixed-point model and checks each result.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

module tb_quadrotor_observer_lqr_mixer_unit;

  localparam logic CFG_HOVER_HEIGHT = 1'b0;
  localparam logic CFG_HOVER_THRUST = 1'b1;
  localparam longint SAT_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint SAT_MIN = 64'sh8000_0000_0000_0000;

  // gain with 32 fraction bits, n/d rounded to nearest
  function automatic longint q32(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] hi;
    logic [63:0] lo;
    hi = ((n << 16) / d) << 16;
    lo = ((((n << 16) % d) << 16) + d / 2) / d;
    return longint'(hi + lo);
  endfunction

  localparam logic [63:0] D8  = 64'd100000000;
  localparam logic [63:0] D13 = 64'd10000000000000;
  localparam logic [63:0] D14 = 64'd100000000000000;

  localparam longint K_DT     = q32(2, 1000);
  localparam longint K_GRAV   = q32(981, 100);
  localparam longint K_DEG    = q32(64'd1745329251994, D14);
  localparam longint K_JXDT   = q32(7, 1000);
  localparam longint K_JYDT   = q32(755, 100000);
  localparam longint K_OBS_H  = q32(64'd24348085654692, D13);
  localparam longint K_OBS_TN = q32(64'd310326377742, D14);
  localparam longint K_OBS_TV = q32(64'd2540055959458, D14);
  localparam longint K_OBS_PN = q32(64'd186080731891, D14);
  localparam longint K_OBS_PV = q32(64'd1523091512296, D14);
  localparam longint K_OBS_XN = q32(64'd8742261792886, D14);
  localparam longint K_OBS_XV = q32(64'd71556386304403, D14);
  localparam longint K_OBS_YN = q32(64'd6749059984201, D14);
  localparam longint K_OBS_YV = q32(64'd55241807539332, D14);
  localparam longint K_OBS_VZ = q32(64'd28565908196855, D13);
  localparam longint K_RX_P   = q32(1153626, D8);
  localparam longint K_RX_A   = q32(2190339, D8);
  localparam longint K_RX_V   = q32(762691, D8);
  localparam longint K_RX_W   = q32(314458, D8);
  localparam longint K_RX_T   = q32(449542642, D8);
  localparam longint K_PY_P   = q32(815737, D8);
  localparam longint K_PY_A   = q32(2001104, D8);
  localparam longint K_PY_V   = q32(631934, D8);
  localparam longint K_PY_W   = q32(311792, D8);
  localparam longint K_PY_T   = q32(427664907, D8);
  localparam longint K_YW_A   = q32(125252, D8);
  localparam longint K_YW_W   = q32(26410, D8);
  localparam longint K_FZ_P   = q32(35649465, D8);
  localparam longint K_FZ_V   = q32(38846142, D8);
  localparam longint K_MIX_T  = q32(36982249, 10);
  localparam longint K_MIX_Z  = q32(1865671642, 10);
  localparam longint K_MIX_F  = q32(147929, 1);

  function automatic longint sat_add(input longint a, input longint b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return longint'(s[63:0]);
  endfunction

  function automatic longint sat_sub(input longint a, input longint b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? SAT_MIN : SAT_MAX;
    return longint'(s[63:0]);
  endfunction

  // value * gain / 2^32, magnitude rounded half up, saturated
  function automatic longint gmul(input longint x, input longint c);
    logic neg;
    logic [63:0] a;
    logic [63:0] b;
    logic [127:0] p;
    logic [63:0] mag;
    neg = (x < 0) != (c < 0);
    a = x < 0 ? 64'(-x) : 64'(x);
    b = c < 0 ? 64'(-c) : 64'(c);
    p = {64'b0, a} * {64'b0, b} + 128'h8000_0000;
    mag = (p[127:96] != 0) ? '1 : p[95:32];
    if (neg) return mag[63] ? SAT_MIN : -longint'(mag);
    return mag[63] ? SAT_MAX : longint'(mag);
  endfunction

  function automatic longint q_s32(input logic [31:0] v);
    return longint'(signed'(v)) <<< 16;
  endfunction

  function automatic longint q_u(input logic [19:0] v);
    return longint'({44'b0, v}) <<< 16;
  endfunction

  function automatic logic [15:0] motor_cmd(input longint v);
    logic [63:0] q;
    if (v <= 0) return 16'd0;
    q = 64'(v) >> 32;
    return q > 64'd65535 ? 16'hFFFF : q[15:0];
  endfunction

  class motor_scoreboard;
    logic [19:0] hover_height;
    logic [18:0] hover_thrust;
    longint px, py, h, yaw, pit, rol, vx, vy, vz, last_wx, last_wy;
    logic [63:0] motor_q[$];
    int mismatches;
    int ticks;
    int checked;
    int disabled_ticks;

    function new();
      hover_height = 20'd32768;
      hover_thrust = 19'd21473;
      {px, py, h, yaw, pit, rol, vx, vy, vz, last_wx, last_wy} = '0;
      mismatches = 0;
      ticks = 0;
      checked = 0;
      disabled_ticks = 0;
    endfunction

    function void write_reg(input logic idx, input logic [19:0] val);
      if (idx == CFG_HOVER_HEIGHT) hover_height = val;
      else hover_thrust = val[18:0];
    endfunction

    function void note_tick(input logic [311:0] d);
      longint grav, eq, tx, ty, tz, wx, wy, wz, acc, fx, fy, rng;
      longint tqx, tqy, cx, cy, cz, thr, s, hterm;
      logic [15:0] m1, m2, m3, m4;
      grav = gmul(64'sd1 <<< 32, K_GRAV);
      eq = q_u(hover_height);
      tx = q_s32(d[31:0]);
      ty = q_s32(d[63:32]);
      tz = q_s32(d[95:64]);
      wx = gmul(q_s32(d[129:98]), K_DEG);
      wy = gmul(q_s32(d[161:130]), K_DEG);
      wz = gmul(q_s32(d[193:162]), K_DEG);
      acc = gmul(q_s32(d[225:194]), K_GRAV);
      fx = q_s32(d[257:226]);
      fy = q_s32(d[289:258]);
      rng = q_u(d[309:290]);
      ticks++;

      tqx = gmul(sat_sub(wx, last_wx), K_JXDT);
      tqy = gmul(sat_sub(wy, last_wy), K_JYDT);
      last_wx = wx;
      last_wy = wy;
      if (d[97]) {px, py, h, yaw, pit, rol, vx, vy, vz} = '0;

      // observer, each line sees the values already updated
      hterm = sat_sub(rng, eq);
      s = sat_add(sat_add(gmul(sat_sub(h, eq), -K_OBS_H), gmul(hterm, K_OBS_H)), vz);
      h = sat_add(h, gmul(s, K_DT));
      s = sat_add(sat_add(gmul(fx, K_OBS_TN), gmul(vx, -K_OBS_TV)), wy);
      pit = sat_add(pit, gmul(s, K_DT));
      s = sat_add(sat_add(gmul(fy, -K_OBS_PN), gmul(vy, K_OBS_PV)), wx);
      rol = sat_add(rol, gmul(s, K_DT));
      s = sat_add(sat_add(gmul(fx, K_OBS_XN), gmul(pit, K_GRAV)), gmul(vx, -K_OBS_XV));
      vx = sat_add(vx, gmul(s, K_DT));
      s = sat_add(sat_add(gmul(fy, K_OBS_YN), gmul(rol, -K_GRAV)), gmul(vy, -K_OBS_YV));
      vy = sat_add(vy, gmul(s, K_DT));
      s = sat_add(sat_add(sat_sub(acc, grav), gmul(sat_sub(h, eq), -K_OBS_VZ)),
                  gmul(hterm, K_OBS_VZ));
      vz = sat_add(vz, gmul(s, K_DT));
      px = sat_add(px, gmul(vx, K_DT));
      py = sat_add(py, gmul(vy, K_DT));
      yaw = sat_add(yaw, gmul(wz, K_DT));

      if (!d[96]) begin
        disabled_ticks++;
        motor_q.push_back(64'd0);
        return;
      end
      cx = sat_add(sat_add(sat_add(sat_add(gmul(sat_sub(py, ty), K_RX_P),
           gmul(rol, -K_RX_A)), gmul(vy, K_RX_V)), gmul(wx, -K_RX_W)), gmul(tqx, -K_RX_T));
      cy = sat_add(sat_add(sat_add(sat_add(gmul(sat_sub(px, tx), -K_PY_P),
           gmul(pit, -K_PY_A)), gmul(vx, -K_PY_V)), gmul(wy, -K_PY_W)), gmul(tqy, -K_PY_T));
      cz = sat_add(gmul(yaw, -K_YW_A), gmul(wz, -K_YW_W));
      thr = sat_add(sat_add(gmul(sat_sub(h, tz), -K_FZ_P), gmul(vz, -K_FZ_V)),
                    q_u({1'b0, hover_thrust}));
      m1 = motor_cmd(sat_add(sat_add(sat_add(gmul(cx, -K_MIX_T), gmul(cy, -K_MIX_T)),
           gmul(cz, -K_MIX_Z)), gmul(thr, K_MIX_F)));
      m2 = motor_cmd(sat_add(sat_add(sat_add(gmul(cx, -K_MIX_T), gmul(cy, K_MIX_T)),
           gmul(cz, K_MIX_Z)), gmul(thr, K_MIX_F)));
      m3 = motor_cmd(sat_add(sat_add(sat_add(gmul(cx, K_MIX_T), gmul(cy, K_MIX_T)),
           gmul(cz, -K_MIX_Z)), gmul(thr, K_MIX_F)));
      m4 = motor_cmd(sat_add(sat_add(sat_add(gmul(cx, K_MIX_T), gmul(cy, -K_MIX_T)),
           gmul(cz, K_MIX_Z)), gmul(thr, K_MIX_F)));
      motor_q.push_back({m4, m3, m2, m1});
    endfunction

    function void check_motors(input logic [63:0] got);
      logic [63:0] want;
      if (motor_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = motor_q.pop_front();
      checked++;
      for (int i = 0; i < 4; i++)
        if (got[16*i +: 16] !== want[16*i +: 16]) begin
          $display("%0t: motor_%0d mismatch, expected %0d, actual %0d", $time, i + 1,
                   want[16*i +: 16], got[16*i +: 16]);
          mismatches++;
        end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic [311:0] s_tdata;
  logic         s_tvalid;
  logic         s_tready;
  logic [63:0]  m_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic         cfg_we;
  logic         cfg_index;
  logic [19:0]  cfg_data;

  motor_scoreboard sb;
  logic hold_req;
  int   burst_left;

  quadrotor_observer_lqr_mixer_unit u_top (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("timeout");
    $display("*** FAILED ***");
    $finish;
  end

  // observe every handshake at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.note_tick(s_tdata);
      if (m_tvalid && m_tready) sb.check_motors(m_tdata);
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int mode;
    int cyc;
    m_tready = 1'b0;
    mode = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (3000) @(negedge clk);
        hold_req = 1'b0;
      end
      cyc++;
      if (cyc % 300 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: m_tready = 1'b1;
        1: m_tready = ($urandom_range(0, 3) != 0);
        2: m_tready = (cyc % 7) < 2;
        default: m_tready = ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  function automatic logic [31:0] rnd_word(input int kind);
    case (kind)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h6_0000)) - 32'sh3_0000);
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  function automatic logic [311:0] pack_tick(
      input logic [31:0] tx, ty, tz, input logic en, clr,
      input logic [31:0] gx, gy, gz, az, fx, fy, input logic [19:0] rng);
    return {2'b0, rng, fy, fx, az, gz, gy, gx, clr, en, tz, ty, tx};
  endfunction

  function automatic logic [311:0] random_tick();
    int k;
    logic [31:0] w[10];
    k = $urandom_range(0, 9) == 0 ? 0 : ($urandom_range(0, 19) == 0 ? 2 : 1);
    for (int i = 0; i < 10; i++) w[i] = rnd_word($urandom_range(0, 4) == 0 ? 0 : k);
    // vertical accel near one g most of the time
    if (k == 1) w[6] = 32'h1_0000 + (w[6] >>> 4);
    return pack_tick(w[0], w[1], w[2], $urandom_range(0, 7) != 0,
                     $urandom_range(0, 24) == 0, w[3], w[4], w[5], w[6], w[7], w[8],
                     $urandom_range(0, 3) == 0 ? 20'($urandom) : $urandom_range(0, 20'h10000));
  endfunction

  task automatic send_tick(input logic [311:0] d);
    s_tdata = d;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    if (--burst_left <= 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
  endtask

  task automatic drain();
    s_tvalid = 1'b0;
    while (sb.motor_q.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [19:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  initial begin
    logic [19:0] heights[6];
    logic [19:0] thrusts[6];
    sb = new();
    rst = 1'b1;
    s_tdata = '0;
    s_tvalid = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HOVER_HEIGHT;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 1;
    repeat (10) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: extremes, motors off, estimate clear, rate steps
    send_tick('0);
    send_tick(pack_tick(0, 0, 32'h1_0000, 1, 0, 0, 0, 0, 32'h1_0000, 0, 0, 20'h8000));
    send_tick(pack_tick('1, '1, '1, 1, 1, '1, '1, '1, '1, '1, '1, '1));
    send_tick(pack_tick(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                        32'h7FFF_FFFF, 20'h80000));
    send_tick(pack_tick(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1, 0, 32'h8000_0000,
                        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                        32'h8000_0000, 20'hFFFFF));
    send_tick(pack_tick(0, 0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h100, 32'h8000_0000,
                        0, 0, 0));
    send_tick(pack_tick(0, 0, 32'h1_0000, 1, 1, 0, 0, 0, 32'h1_0000, 0, 0, 20'h8000));
    for (int i = 0; i < 6; i++)
      send_tick(pack_tick(32'h2_0000, 32'hFFFE_0000, 32'h1_8000, 1, 0,
                          i[0] ? 32'h0100_0000 : 32'hFF00_0000,
                          i[0] ? 32'hFF00_0000 : 32'h0100_0000, 32'h10_0000, 32'h1_0000,
                          32'h3_0000, 32'hFFFD_0000, 20'h1_0000));
    for (int i = 0; i < 8; i++) send_tick(random_tick());
    drain();

    heights = '{20'd0, 20'd524288, 20'hFFFFF, 20'd65536, 20'd32768, 20'($urandom)};
    thrusts = '{20'd0, 20'd262144, 20'h7FFFF, 20'hFFFFF, 20'd21473, 20'($urandom)};
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_HOVER_HEIGHT, heights[ph]);
      write_reg(CFG_HOVER_THRUST, thrusts[ph]);
      for (int n = 0; n < 180; n++) begin
        if (ph == 2 && n == 40) hold_req = 1'b1;
        if (ph == 3 && n == 90) drain();
        send_tick(random_tick());
      end
      drain();
    end

    for (int i = 0; i < 2000 && sb.motor_q.size() != 0; i++) @(negedge clk);
    repeat (500) @(negedge clk);
    if (sb.motor_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, sb.motor_q.size());
      sb.mismatches++;
    end
    $display("%0d ticks sent over 7 register settings, %0d results checked (%0d with motors off)",
             sb.ticks, sb.checked, sb.disabled_ticks);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
